// File: sv/assert_macros.svh
// Assertion macros used by the blit RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks an implication property on every rising edge outside reset.
`define ASSERT_CLK(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Checks that a condition never holds on a rising edge outside reset.
`define ASSERT_NEVER(label, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) else $error(msg);

`endif

// File: sv/gr4b_pkg.sv
package gr4b_pkg;

	localparam int GLYPH_ROWS_DEF = 16;
	localparam int AREA_BYTES_DEF = 4096;

	localparam int BITS_W    = 16;
	localparam int GWIDTH_W  = 5;
	localparam int START_W   = 8;
	localparam int ROW_W     = 4;
	localparam int LWIDTH_W  = 10;
	localparam int ADDR_W    = 12;
	localparam int BYTE_W    = 8;
	localparam int COLOR_W   = 4;
	localparam int COUNT_W   = 4;
	localparam int SUM_W     = 14;
	localparam int ROW_DEPTH = 2 ** ROW_W;

	localparam logic [GWIDTH_W-1:0] MAX_WIDTH = GWIDTH_W'(16);

	localparam logic [BITS_W-1:0]  INK_FIRST  = 16'h8000;
	localparam logic [BITS_W-1:0]  INK_SECOND = 16'h4000;
	localparam logic [COLOR_W-1:0] NIBBLE     = 4'hf;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_REDUCE,
		ST_EMIT
	} state_t;

endpackage

// File: sv/gr4b_if.sv
interface gr4b_in_if;
	logic                            valid;
	logic                            ready;
	logic [gr4b_pkg::BITS_W-1:0]     row_bits;
	logic [gr4b_pkg::GWIDTH_W-1:0]   row_width;
	logic [gr4b_pkg::START_W-1:0]    start_pixel;
	logic [gr4b_pkg::ROW_W-1:0]      row_index;
	logic [gr4b_pkg::LWIDTH_W-1:0]   line_width;

	modport source (
		output valid, row_bits, row_width, start_pixel, row_index, line_width,
		input  ready
	);
	modport sink (
		input  valid, row_bits, row_width, start_pixel, row_index, line_width,
		output ready
	);
endinterface

interface gr4b_out_if;
	logic                          valid;
	logic                          ready;
	logic [gr4b_pkg::ADDR_W-1:0]   byte_addr;
	logic [gr4b_pkg::BYTE_W-1:0]   byte_value;
	logic                          last;

	modport source (
		output valid, byte_addr, byte_value, last,
		input  ready
	);
	modport sink (
		input  valid, byte_addr, byte_value, last,
		output ready
	);
endinterface

// File: sv/gr4b_row_store.sv
module gr4b_row_store #(
	parameter int GLYPH_ROWS = gr4b_pkg::GLYPH_ROWS_DEF
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   wr_en,
	input  logic [((GLYPH_ROWS > 1) ? $clog2(GLYPH_ROWS) : 1)-1:0] wr_slot,
	input  logic [gr4b_pkg::BYTE_W-1:0]            wr_data,
	input  logic [((GLYPH_ROWS > 1) ? $clog2(GLYPH_ROWS) : 1)-1:0] rd_slot,
	output logic [gr4b_pkg::BYTE_W-1:0]            rd_data
);

	logic [gr4b_pkg::BYTE_W-1:0] last_byte_q [GLYPH_ROWS];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < GLYPH_ROWS; i++) begin
				last_byte_q[i] <= '0;
			end
		end else if (wr_en) begin
			last_byte_q[wr_slot] <= wr_data;
		end
	end

	assign rd_data = last_byte_q[rd_slot];

endmodule

// File: sv/glyph_row_to_4bpp_blit.sv
// Flow: REDUCE subtracts AREA_BYTES R times, where R = floor(A / AREA_BYTES) and
// A = start_pixel/2 + row_index*pitch; one compare-subtract unit takes one pass a cycle.
// EMIT then writes N bytes (1 to 9), each held until byte_out.ready, and no new row is
// taken until the last one is out; R is zero for every row when AREA_BYTES exceeds 7807.
// A row that writes no byte is taken while idle and leaves the sequencer idle.
// Reset: arst_n clears the sequencer, color_q and every stored last byte to zero.
`include "assert_macros.svh"

module glyph_row_to_4bpp_blit #(
	parameter int GLYPH_ROWS = gr4b_pkg::GLYPH_ROWS_DEF,
	parameter int AREA_BYTES = gr4b_pkg::AREA_BYTES_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	gr4b_in_if.sink                        glyph_in,
	gr4b_out_if.source                     byte_out,
	input  logic                           cfg_wr_en,
	input  logic [gr4b_pkg::COLOR_W-1:0]   cfg_wr_data
);

	localparam int SLOT_W = (GLYPH_ROWS > 1) ? $clog2(GLYPH_ROWS) : 1;
	localparam int AREA_W = $clog2(AREA_BYTES) + 1;
	localparam int ACC_W  = (AREA_W > gr4b_pkg::SUM_W) ? AREA_W : gr4b_pkg::SUM_W;
	localparam logic [ACC_W-1:0] AREA = ACC_W'(AREA_BYTES);

	gr4b_pkg::state_t state_q, state_d;

	logic [gr4b_pkg::COLOR_W-1:0] color_q;
	logic [ACC_W-1:0]             acc_q;
	logic [gr4b_pkg::BITS_W-1:0]  bits_q;
	logic [gr4b_pkg::COUNT_W-1:0] cnt_q;
	logic                         first_q;
	logic [SLOT_W-1:0]            slot_q;

	logic [SLOT_W-1:0] slot_lut [gr4b_pkg::ROW_DEPTH];

	for (genvar r = 0; r < gr4b_pkg::ROW_DEPTH; r++) begin : g_slot
		assign slot_lut[r] = SLOT_W'(r % GLYPH_ROWS);
	end

	logic [gr4b_pkg::GWIDTH_W-1:0] width_sat;
	logic [gr4b_pkg::GWIDTH_W-1:0] width_rest;
	logic                          odd_start;
	logic [gr4b_pkg::COUNT_W-1:0]  pair_cnt;
	logic [gr4b_pkg::COUNT_W-1:0]  byte_cnt;
	logic [8:0]                    pitch_half;
	logic [gr4b_pkg::LWIDTH_W-1:0] pitch;
	logic [gr4b_pkg::SUM_W-1:0]    base_sum;

	always_comb begin
		width_sat  = (glyph_in.row_width > gr4b_pkg::MAX_WIDTH) ?
		             gr4b_pkg::MAX_WIDTH : glyph_in.row_width;
		odd_start  = glyph_in.start_pixel[0];
		if (odd_start && (width_sat != '0)) begin
			width_rest = width_sat - gr4b_pkg::GWIDTH_W'(1);
		end else begin
			width_rest = width_sat;
		end
		pair_cnt   = gr4b_pkg::COUNT_W'((6'(width_rest) + 6'd1) >> 1);
		byte_cnt   = pair_cnt + gr4b_pkg::COUNT_W'(odd_start);
		pitch_half = 9'((11'(glyph_in.line_width) + 11'd3) >> 2);
		pitch      = {pitch_half, 1'b0};
		base_sum   = gr4b_pkg::SUM_W'(gr4b_pkg::SUM_W'(glyph_in.row_index) *
		                              gr4b_pkg::SUM_W'(pitch)) +
		             gr4b_pkg::SUM_W'(glyph_in.start_pixel[gr4b_pkg::START_W-1:1]);
	end

	// Shared compare-subtract unit: reduces the start address, then wraps each increment.
	logic [ACC_W-1:0] unit_in;
	logic             unit_ge;
	logic [ACC_W-1:0] unit_res;

	always_comb begin
		unit_in  = (state_q == gr4b_pkg::ST_REDUCE) ? acc_q : acc_q + ACC_W'(1);
		unit_ge  = unit_in >= AREA;
		unit_res = unit_ge ? unit_in - AREA : unit_in;
	end

	logic [gr4b_pkg::BYTE_W-1:0]  stored_byte;
	logic [gr4b_pkg::COLOR_W-1:0] nib_lo;
	logic [gr4b_pkg::COLOR_W-1:0] nib_hi;
	logic                         out_beat;
	logic                         store_wr;

	always_comb begin
		nib_lo = ((bits_q & gr4b_pkg::INK_FIRST) == '0) ? color_q : '0;
		nib_hi = ((bits_q & gr4b_pkg::INK_SECOND) == '0) ? color_q : '0;
		byte_out.byte_addr = acc_q[gr4b_pkg::ADDR_W-1:0];
		if (first_q) begin
			byte_out.byte_value = stored_byte | {nib_lo, 4'b0000};
		end else begin
			byte_out.byte_value = {nib_hi, nib_lo};
		end
		byte_out.last = cnt_q == gr4b_pkg::COUNT_W'(1);
		out_beat      = byte_out.valid && byte_out.ready;
		store_wr      = out_beat && byte_out.last;
	end

	gr4b_row_store #(
		.GLYPH_ROWS (GLYPH_ROWS)
	) u_row_store (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (store_wr),
		.wr_slot (slot_q),
		.wr_data (byte_out.byte_value),
		.rd_slot (slot_q),
		.rd_data (stored_byte)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= gr4b_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d        = state_q;
		glyph_in.ready = 1'b0;
		byte_out.valid = 1'b0;
		unique case (state_q)
			gr4b_pkg::ST_IDLE: begin
				glyph_in.ready = 1'b1;
				if (glyph_in.valid && (byte_cnt != '0)) begin
					state_d = gr4b_pkg::ST_REDUCE;
				end
			end
			gr4b_pkg::ST_REDUCE: begin
				if (!unit_ge) begin
					state_d = gr4b_pkg::ST_EMIT;
				end
			end
			gr4b_pkg::ST_EMIT: begin
				byte_out.valid = 1'b1;
				if (byte_out.ready && byte_out.last) begin
					state_d = gr4b_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = gr4b_pkg::ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			color_q <= '0;
		end else if (cfg_wr_en) begin
			color_q <= cfg_wr_data & gr4b_pkg::NIBBLE;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q   <= '0;
			first_q <= 1'b0;
		end else if (glyph_in.valid && glyph_in.ready) begin
			cnt_q   <= byte_cnt;
			first_q <= odd_start;
		end else if (out_beat) begin
			cnt_q   <= cnt_q - gr4b_pkg::COUNT_W'(1);
			first_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (glyph_in.valid && glyph_in.ready) begin
			acc_q  <= ACC_W'(base_sum);
			bits_q <= glyph_in.row_bits;
			slot_q <= slot_lut[glyph_in.row_index];
		end else if (state_q == gr4b_pkg::ST_REDUCE) begin
			acc_q <= unit_res;
		end else if (out_beat) begin
			acc_q  <= unit_res;
			bits_q <= first_q ? (bits_q << 1) : (bits_q << 2);
		end
	end

	`ASSERT_NEVER(a_ready_while_busy, glyph_in.ready && byte_out.valid, "ready during output")
	`ASSERT_CLK(a_addr_in_range, (state_q == gr4b_pkg::ST_EMIT) |-> (acc_q < AREA), "address not wrapped")
	`ASSERT_CLK(a_cnt_nonzero, (state_q == gr4b_pkg::ST_EMIT) |-> (cnt_q != '0), "emit with no bytes left")
	`ASSERT_CLK(a_last_ends_row, (out_beat && byte_out.last) |=> (state_q == gr4b_pkg::ST_IDLE), "row did not end on last")

endmodule

// File: verif/glyph_row_to_4bpp_blit_tb.sv
`timescale 1ns / 100ps

module glyph_row_to_4bpp_blit_tb;

	localparam int ROWS = gr4b_pkg::GLYPH_ROWS_DEF;
	localparam int AREA = gr4b_pkg::AREA_BYTES_DEF;
	localparam int CYCLE_LIMIT = 200000;
	localparam int SETTLE_CYCLES = 24;
	localparam int LONG_HOLD = 250;
	localparam int ROWS_PER_PHASE = 134;

	typedef struct {
		logic [gr4b_pkg::BITS_W-1:0]   row_bits;
		logic [gr4b_pkg::GWIDTH_W-1:0] row_width;
		logic [gr4b_pkg::START_W-1:0]  start_pixel;
		logic [gr4b_pkg::ROW_W-1:0]    row_index;
		logic [gr4b_pkg::LWIDTH_W-1:0] line_width;
	} glyph_row_t;

	typedef struct {
		logic [gr4b_pkg::ADDR_W-1:0] byte_addr;
		logic [gr4b_pkg::BYTE_W-1:0] byte_value;
		logic                        last;
	} buf_byte_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_wr_en = 1'b0;
	logic [gr4b_pkg::COLOR_W-1:0] cfg_wr_data = '0;

	gr4b_in_if  glyph_in();
	gr4b_out_if byte_out();

	glyph_row_to_4bpp_blit i_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.glyph_in    (glyph_in),
		.byte_out    (byte_out),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data)
	);

	glyph_row_t pending_rows[$];
	buf_byte_t expected_bytes[$];
	glyph_row_t offered_row;

	logic [gr4b_pkg::COLOR_W-1:0] ink_color = '0;
	logic [gr4b_pkg::BYTE_W-1:0] row_last_byte[ROWS];

	int send_gap_pct = 0;
	int recv_stall_pct = 0;
	bit hold_armed = 1'b0;
	bit hold_done = 1'b0;
	int hold_left = 0;
	int fail_count = 0;
	int cycle_count = 0;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Expands one glyph row into the buffer bytes it writes and updates the
	// stored last byte of its glyph row.
	function automatic void expand_glyph_row(glyph_row_t r);
		logic [gr4b_pkg::BITS_W-1:0] bits;
		logic [gr4b_pkg::BYTE_W-1:0] val;
		int unsigned width, slot, pitch, addr, lw, total, k;
		bits = r.row_bits;
		width = r.row_width;
		if (width > 16)
			width = 16;
		slot = r.row_index % ROWS;
		lw = r.line_width;
		pitch = ((lw + 3) / 4) * 2;
		addr = (int'(r.start_pixel) / 2 + int'(r.row_index) * pitch) % AREA;
		total = r.start_pixel[0] ? 1 + ((width > 0 ? width - 1 : 0) + 1) / 2 : (width + 1) / 2;
		k = 0;
		val = '0;
		if (r.start_pixel[0]) begin
			val = row_last_byte[slot];
			if ((bits & gr4b_pkg::INK_FIRST) == 0)
				val = val | {ink_color, 4'h0};
			expected_bytes.push_back('{addr[gr4b_pkg::ADDR_W-1:0], val, k == total - 1});
			k++;
			addr = (addr + 1) % AREA;
			if (width > 0)
				width--;
			bits = bits << 1;
		end
		while (width > 0) begin
			val = '0;
			if ((bits & gr4b_pkg::INK_FIRST) == 0)
				val[3:0] = ink_color;
			if ((bits & gr4b_pkg::INK_SECOND) == 0)
				val[7:4] = ink_color;
			expected_bytes.push_back('{addr[gr4b_pkg::ADDR_W-1:0], val, k == total - 1});
			k++;
			addr = (addr + 1) % AREA;
			bits = bits << 2;
			width = (width > 2) ? width - 2 : 0;
		end
		if (k > 0)
			row_last_byte[slot] = val;
	endfunction

	always @(posedge clk or negedge arst_n) begin : row_driver
		bit offer;
		if (!arst_n) begin
			glyph_in.valid <= 1'b0;
			glyph_in.row_bits <= '0;
			glyph_in.row_width <= '0;
			glyph_in.start_pixel <= '0;
			glyph_in.row_index <= '0;
			glyph_in.line_width <= '0;
			foreach (row_last_byte[i])
				row_last_byte[i] = '0;
		end else begin
			if (glyph_in.valid && glyph_in.ready)
				expand_glyph_row(offered_row);
			if (!glyph_in.valid || glyph_in.ready) begin
				offer = pending_rows.size() > 0 && $urandom_range(99) >= send_gap_pct;
				if (offer) begin
					offered_row = pending_rows.pop_front();
					glyph_in.valid <= 1'b1;
					glyph_in.row_bits <= offered_row.row_bits;
					glyph_in.row_width <= offered_row.row_width;
					glyph_in.start_pixel <= offered_row.start_pixel;
					glyph_in.row_index <= offered_row.row_index;
					glyph_in.line_width <= offered_row.line_width;
				end else begin
					glyph_in.valid <= 1'b0;
				end
			end
		end
	end

	always @(posedge clk or negedge arst_n) begin : byte_monitor
		buf_byte_t want;
		if (!arst_n) begin
			byte_out.ready <= 1'b0;
		end else begin
			if (byte_out.valid && byte_out.ready) begin
				if (expected_bytes.size() == 0) begin
					$error("unexpected beat: byte_addr %0d byte_value 0x%02h last %0b",
						byte_out.byte_addr, byte_out.byte_value, byte_out.last);
					fail_count++;
				end else begin
					want = expected_bytes.pop_front();
					if (byte_out.byte_addr !== want.byte_addr) begin
						$error("byte_addr: expected %0d, actual %0d",
							want.byte_addr, byte_out.byte_addr);
						fail_count++;
					end
					if (byte_out.byte_value !== want.byte_value) begin
						$error("byte_value: expected 0x%02h, actual 0x%02h",
							want.byte_value, byte_out.byte_value);
						fail_count++;
					end
					if (byte_out.last !== want.last) begin
						$error("last: expected %0b, actual %0b", want.last, byte_out.last);
						fail_count++;
					end
				end
			end
			if (hold_armed && !hold_done && expected_bytes.size() > 0) begin
				hold_left = LONG_HOLD;
				hold_done = 1'b1;
			end
			if (hold_left > 0) begin
				hold_left--;
				byte_out.ready <= 1'b0;
			end else begin
				byte_out.ready <= ($urandom_range(99) >= recv_stall_pct);
			end
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("== FAIL ==");
			$finish;
		end
	end

	function automatic glyph_row_t random_row();
		glyph_row_t r;
		int pick;
		pick = $urandom_range(9);
		if (pick == 0)
			r.row_bits = '0;
		else if (pick == 1)
			r.row_bits = '1;
		else
			r.row_bits = gr4b_pkg::BITS_W'($urandom());
		pick = $urandom_range(9);
		if (pick == 0)
			r.row_width = gr4b_pkg::GWIDTH_W'($urandom_range(31, 17));
		else if (pick == 1)
			r.row_width = '0;
		else
			r.row_width = gr4b_pkg::GWIDTH_W'($urandom_range(16, 1));
		r.start_pixel = gr4b_pkg::START_W'($urandom_range(255));
		r.row_index = gr4b_pkg::ROW_W'($urandom_range(15));
		pick = $urandom_range(9);
		if (pick == 0)
			r.line_width = '1;
		else if (pick == 1)
			r.line_width = '0;
		else
			r.line_width = gr4b_pkg::LWIDTH_W'($urandom_range(1023));
		return r;
	endfunction

	// Most rows come as runs of glyphs laid side by side on one glyph row,
	// so that odd starts merge into the byte left by the glyph before.
	task automatic queue_rows(input int count);
		glyph_row_t r, prev;
		int run_left, k;
		run_left = 0;
		for (k = 0; k < count; k++) begin
			r = random_row();
			if (run_left > 0) begin
				r.row_index = prev.row_index;
				r.line_width = prev.line_width;
				r.start_pixel = prev.start_pixel +
					gr4b_pkg::START_W'(prev.row_width > gr4b_pkg::MAX_WIDTH ?
					gr4b_pkg::MAX_WIDTH : prev.row_width);
				run_left--;
			end else if ($urandom_range(3) != 0) begin
				run_left = $urandom_range(5, 1);
			end
			pending_rows.push_back(r);
			prev = r;
		end
	endtask

	task automatic push_row(input logic [gr4b_pkg::BITS_W-1:0] bits, input int width,
			input int start, input int row, input int lw);
		pending_rows.push_back('{bits, gr4b_pkg::GWIDTH_W'(width),
			gr4b_pkg::START_W'(start), gr4b_pkg::ROW_W'(row), gr4b_pkg::LWIDTH_W'(lw)});
	endtask

	task automatic wait_idle();
		@(negedge clk);
		while (pending_rows.size() != 0 || glyph_in.valid || expected_bytes.size() != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic write_color(input logic [gr4b_pkg::COLOR_W-1:0] color);
		@(posedge clk);
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= color;
		ink_color = color;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
	endtask

	task automatic run_phase(input int gap_pct, input int stall_pct,
			input logic [gr4b_pkg::COLOR_W-1:0] color, input bit long_hold);
		wait_idle();
		write_color(color);
		@(negedge clk);
		send_gap_pct = gap_pct;
		recv_stall_pct = stall_pct;
		queue_rows(ROWS_PER_PHASE);
		hold_armed = long_hold;
	endtask

	initial begin
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		write_color(4'hf);
		@(negedge clk);
		push_row(16'h0000, 16, 0, 0, 0);
		push_row(16'hffff, 16, 1, 0, 1023);
		push_row(16'h5555, 15, 2, 1, 1023);
		push_row(16'haaaa, 31, 255, 15, 1023);
		push_row(16'h0000, 0, 3, 2, 100);
		push_row(16'h0000, 0, 4, 2, 100);
		push_row(16'h8001, 1, 0, 3, 9);
		push_row(16'h7ffe, 1, 1, 3, 9);
		push_row(16'hffff, 2, 1, 3, 9);
		push_row(16'hffff, 17, 0, 4, 1023);
		push_row(16'h1234, 16, 254, 15, 1023);
		push_row(16'hfffe, 16, 0, 15, 1020);
		push_row(16'h0001, 7, 127, 8, 513);
		push_row(16'hc3c3, 24, 128, 7, 2);
		push_row(16'hffff, 0, 1, 15, 1023);
		push_row(16'h0f0f, 9, 33, 5, 1021);
		push_row(16'hffff, 16, 0, 5, 1);
		push_row(16'h0000, 31, 1, 5, 1);
		run_phase(35, 50, 4'h0, 1'b0);
		run_phase(50, 35, 4'h6, 1'b0);
		run_phase(0, 0, 4'h9, 1'b1);
		wait_idle();
		if (fail_count == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule

// File: glyph_row_to_4bpp_blit.f
+incdir+sv
sv/gr4b_pkg.sv
sv/gr4b_if.sv
sv/gr4b_row_store.sv
sv/glyph_row_to_4bpp_blit.sv
verif/glyph_row_to_4bpp_blit_tb.sv
